// File: design/ascon128_aead_engine_unit_defines.svh
`ifndef ASCON128_AEAD_ENGINE_UNIT_DEFINES_SVH
`define ASCON128_AEAD_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/asc_pkg.sv
package asc_pkg;

  typedef logic [4:0][63:0] lanes_t;

  typedef enum logic [3:0] {
    REQ_INIT     = 4'd0,
    REQ_AD_FULL  = 4'd1,
    REQ_AD_PART  = 4'd2,
    REQ_AD_NONE  = 4'd3,
    REQ_ENC_FULL = 4'd4,
    REQ_ENC_LAST = 4'd5,
    REQ_DEC_FULL = 4'd6,
    REQ_DEC_LAST = 4'd7,
    REQ_FINAL    = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       ready;
    logic       round_en;
    logic       last_round;
    logic       out_load;
    logic [3:0] round_idx;
  } ctl_t;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(1);

  localparam logic [63:0] ASCON_IV   = 64'h80400c0600000000;
  localparam logic [3:0]  FIRST_FULL = 4'd0;
  localparam logic [3:0]  FIRST_DATA = 4'd6;
  localparam logic [3:0]  LAST_ROUND = 4'd11;
  localparam logic [3:0]  BLOCK_BYTES = 4'd8;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [7:0] round_const(input logic [3:0] r);
    logic [7:0] c;
    unique case (r)
      4'd0:    c = 8'hf0;
      4'd1:    c = 8'he1;
      4'd2:    c = 8'hd2;
      4'd3:    c = 8'hc3;
      4'd4:    c = 8'hb4;
      4'd5:    c = 8'ha5;
      4'd6:    c = 8'h96;
      4'd7:    c = 8'h87;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h69;
      4'd10:   c = 8'h5a;
      4'd11:   c = 8'h4b;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // first n bytes of a big-endian word
  function automatic logic [63:0] head_mask(input logic [2:0] n);
    return ~({64{1'b1}} >> {n, 3'b000});
  endfunction

  // padding byte at byte position n
  function automatic logic [63:0] pad_word(input logic [2:0] n);
    return 64'h8000_0000_0000_0000 >> {n, 3'b000};
  endfunction

endpackage

// File: design/asc_ifs.sv
interface asc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [63:0] data_in;
  logic [2:0]  byte_count;
  logic [63:0] nonce_high;
  logic [63:0] nonce_low;

  modport source (output valid, req_type, data_in, byte_count, nonce_high, nonce_low,
                  input ready);
  modport sink (input valid, req_type, data_in, byte_count, nonce_high, nonce_low,
                output ready);
endinterface

interface asc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_bytes;
  logic [63:0] tag_high;
  logic [63:0] tag_low;

  modport source (output valid, out_data, out_bytes, tag_high, tag_low, input ready);
  modport sink (input valid, out_data, out_bytes, tag_high, tag_low, output ready);
endinterface

interface asc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asc_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/ascon128_aead_engine_unit.sv
// ASCON-128 AEAD engine, one 64-bit block per request. The permutation runs one
// round per clock in a single shared round unit, stepped by a small sequencer;
// the block takes no new request from the accepting edge until the result has
// moved into the output register. Init and finalize run 12 rounds; full
// associated-data, encrypt and decrypt blocks and a last partial
// associated-data block run 6 rounds; the other requests run no permutation.
// The output register holds a result until it is taken; the following request
// can already be accepted while that result waits there, and its own result
// moves in only once the register is free. The key registers are written
// through the configuration port, which is always ready.
module ascon128_aead_engine_unit (
  input logic             clk,
  input logic             rst_n,
  asc_in_if.sink          in_ch,
  asc_out_if.source       out_ch,
  asc_cfg_if.sink         cfg_ch
);

  asc_pkg::ctl_t   ctl;
  asc_pkg::lanes_t lanes_r, lanes_nxt, rnd_out, acc_lanes;
  logic [63:0]     key_hi_r, key_lo_r;
  logic [63:0]     od_r, od_nxt, tag_hi_r, tag_hi_nxt, tag_lo_r, tag_lo_nxt;
  logic [3:0]      ob_r, ob_nxt;
  logic            post_key_r, post_key_nxt, post_ds_r, post_ds_nxt;
  logic            tag_cap_r, tag_cap_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_data_r, out_tag_hi_r, out_tag_lo_r;
  logic [3:0]      out_bytes_r;

  logic            in_fire, out_free;
  logic [63:0]     acc_od, mask, pad;
  logic [3:0]      acc_ob, acc_first;
  logic            acc_perm, acc_pkey, acc_pds, acc_tcap;

  assign in_fire     = in_ch.valid && ctl.ready;
  assign in_ch.ready = ctl.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_data  = out_data_r;
  assign out_ch.out_bytes = out_bytes_r;
  assign out_ch.tag_high  = out_tag_hi_r;
  assign out_ch.tag_low   = out_tag_lo_r;

  asc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .perm_req  (acc_perm),
    .first_rnd (acc_first),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  asc_round u_round (
    .s_in  (lanes_r),
    .rnd   (ctl.round_idx),
    .s_out (rnd_out)
  );

  always_comb begin
    mask      = asc_pkg::head_mask(in_ch.byte_count);
    pad       = asc_pkg::pad_word(in_ch.byte_count);
    acc_lanes = lanes_r;
    acc_od    = '0;
    acc_ob    = '0;
    acc_perm  = 1'b0;
    acc_first = asc_pkg::FIRST_DATA;
    acc_pkey  = 1'b0;
    acc_pds   = 1'b0;
    acc_tcap  = 1'b0;
    unique case (in_ch.req_type)
      asc_pkg::REQ_INIT: begin
        acc_lanes[0] = asc_pkg::ASCON_IV;
        acc_lanes[1] = key_hi_r;
        acc_lanes[2] = key_lo_r;
        acc_lanes[3] = in_ch.nonce_high;
        acc_lanes[4] = in_ch.nonce_low;
        acc_perm     = 1'b1;
        acc_first    = asc_pkg::FIRST_FULL;
        acc_pkey     = 1'b1;
      end
      asc_pkg::REQ_AD_FULL: begin
        acc_lanes[0] = lanes_r[0] ^ in_ch.data_in;
        acc_perm     = 1'b1;
      end
      asc_pkg::REQ_AD_PART: begin
        acc_lanes[0] = lanes_r[0] ^ ((in_ch.data_in & mask) | pad);
        acc_perm     = 1'b1;
        acc_pds      = 1'b1;
      end
      asc_pkg::REQ_AD_NONE: begin
        acc_lanes[4] = lanes_r[4] ^ 64'd1;
      end
      asc_pkg::REQ_ENC_FULL: begin
        acc_lanes[0] = lanes_r[0] ^ in_ch.data_in;
        acc_od       = acc_lanes[0];
        acc_ob       = asc_pkg::BLOCK_BYTES;
        acc_perm     = 1'b1;
      end
      asc_pkg::REQ_ENC_LAST: begin
        acc_lanes[0] = lanes_r[0] ^ ((in_ch.data_in & mask) | pad);
        acc_od       = acc_lanes[0] & mask;
        acc_ob       = {1'b0, in_ch.byte_count};
      end
      asc_pkg::REQ_DEC_FULL: begin
        acc_od       = lanes_r[0] ^ in_ch.data_in;
        acc_ob       = asc_pkg::BLOCK_BYTES;
        acc_lanes[0] = in_ch.data_in;
        acc_perm     = 1'b1;
      end
      asc_pkg::REQ_DEC_LAST: begin
        acc_od       = (lanes_r[0] ^ in_ch.data_in) & mask;
        acc_ob       = {1'b0, in_ch.byte_count};
        acc_lanes[0] = ((in_ch.data_in & mask) | (lanes_r[0] & ~mask)) ^ pad;
      end
      asc_pkg::REQ_FINAL: begin
        acc_lanes[1] = lanes_r[1] ^ key_hi_r;
        acc_lanes[2] = lanes_r[2] ^ key_lo_r;
        acc_perm     = 1'b1;
        acc_first    = asc_pkg::FIRST_FULL;
        acc_pkey     = 1'b1;
        acc_tcap     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lanes_nxt     = lanes_r;
    od_nxt        = od_r;
    ob_nxt        = ob_r;
    tag_hi_nxt    = tag_hi_r;
    tag_lo_nxt    = tag_lo_r;
    post_key_nxt  = post_key_r;
    post_ds_nxt   = post_ds_r;
    tag_cap_nxt   = tag_cap_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_fire) begin
      lanes_nxt    = acc_lanes;
      od_nxt       = acc_od;
      ob_nxt       = acc_ob;
      tag_hi_nxt   = '0;
      tag_lo_nxt   = '0;
      post_key_nxt = acc_pkey;
      post_ds_nxt  = acc_pds;
      tag_cap_nxt  = acc_tcap;
    end else if (ctl.round_en) begin
      lanes_nxt = rnd_out;
      if (ctl.last_round) begin
        if (post_key_r) begin
          lanes_nxt[3] = rnd_out[3] ^ key_hi_r;
          lanes_nxt[4] = rnd_out[4] ^ key_lo_r;
        end
        if (post_ds_r) begin
          lanes_nxt[4] = rnd_out[4] ^ 64'd1;
        end
        if (tag_cap_r) begin
          tag_hi_nxt = lanes_nxt[3];
          tag_lo_nxt = lanes_nxt[4];
        end
      end
    end
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_r     <= '0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      post_key_r  <= 1'b0;
      post_ds_r   <= 1'b0;
      tag_cap_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lanes_r     <= lanes_nxt;
      post_key_r  <= post_key_nxt;
      post_ds_r   <= post_ds_nxt;
      tag_cap_r   <= tag_cap_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.index == asc_pkg::CFG_KEY_HIGH) begin
        key_hi_r <= cfg_ch.data;
      end
      if (cfg_ch.valid && cfg_ch.index == asc_pkg::CFG_KEY_LOW) begin
        key_lo_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r     <= od_nxt;
    ob_r     <= ob_nxt;
    tag_hi_r <= tag_hi_nxt;
    tag_lo_r <= tag_lo_nxt;
    if (ctl.out_load) begin
      out_data_r   <= od_r;
      out_bytes_r  <= ob_r;
      out_tag_hi_r <= tag_hi_r;
      out_tag_lo_r <= tag_lo_r;
    end
  end

endmodule

// File: design/asc_round.sv
module asc_round (
  input  asc_pkg::lanes_t s_in,
  input  logic [3:0]      rnd,
  output asc_pkg::lanes_t s_out
);

  logic [63:0] a0, b0, c0, d0, e0;
  logic [63:0] a1, b1, c1, d1, e1;
  logic [63:0] a2, b2, c2, d2, e2;

  always_comb begin
    c0 = s_in[2] ^ {56'd0, asc_pkg::round_const(rnd)};
    a0 = s_in[0] ^ s_in[4];
    e0 = s_in[4] ^ s_in[3];
    c0 = c0 ^ s_in[1];
    b0 = s_in[1];
    d0 = s_in[3];

    // chi
    a1 = a0 ^ (~b0 & c0);
    b1 = b0 ^ (~c0 & d0);
    c1 = c0 ^ (~d0 & e0);
    d1 = d0 ^ (~e0 & a0);
    e1 = e0 ^ (~a0 & b0);

    b2 = b1 ^ a1;
    a2 = a1 ^ e1;
    d2 = d1 ^ c1;
    c2 = ~c1;
    e2 = e1;

    // linear diffusion
    s_out[0] = a2 ^ asc_pkg::rotr(a2, 19) ^ asc_pkg::rotr(a2, 28);
    s_out[1] = b2 ^ asc_pkg::rotr(b2, 61) ^ asc_pkg::rotr(b2, 39);
    s_out[2] = c2 ^ asc_pkg::rotr(c2, 1) ^ asc_pkg::rotr(c2, 6);
    s_out[3] = d2 ^ asc_pkg::rotr(d2, 10) ^ asc_pkg::rotr(d2, 17);
    s_out[4] = e2 ^ asc_pkg::rotr(e2, 7) ^ asc_pkg::rotr(e2, 41);
  end

endmodule

// File: design/asc_seq.sv
module asc_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          perm_req,
  input  logic [3:0]    first_rnd,
  input  logic          out_free,
  output asc_pkg::ctl_t ctl
);

  asc_pkg::state_t state_r, state_nxt;
  logic [3:0]      rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asc_pkg::ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    ctl.ready      = 1'b0;
    ctl.round_en   = 1'b0;
    ctl.last_round = 1'b0;
    ctl.out_load   = 1'b0;
    ctl.round_idx  = rnd_r;
    unique case (state_r)
      asc_pkg::ST_IDLE: begin
        ctl.ready = 1'b1;
        if (in_fire) begin
          if (perm_req) begin
            state_nxt = asc_pkg::ST_ROUND;
            rnd_nxt   = first_rnd;
          end else begin
            state_nxt = asc_pkg::ST_DONE;
          end
        end
      end
      asc_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        if (rnd_r == asc_pkg::LAST_ROUND) begin
          ctl.last_round = 1'b1;
          state_nxt      = asc_pkg::ST_DONE;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      asc_pkg::ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = asc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = asc_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/asc_checker.sv
`include "ascon128_aead_engine_unit_defines.svh"

module asc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_data,
  input logic [3:0]  out_bytes,
  input logic [63:0] tag_high,
  input logic [63:0] tag_low
);

  `ASC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")
  `ASC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `ASC_ASSERT_NOW(a_bytes_range, out_valid, out_bytes <= 4'd8, "byte count out of range")
  `ASC_ASSERT_NOW(a_tag_alone, out_valid && out_bytes != 4'd0, tag_high == 64'd0 && tag_low == 64'd0, "tag with data")

endmodule

bind ascon128_aead_engine_unit asc_checker u_asc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.out_data),
  .out_bytes (out_ch.out_bytes),
  .tag_high  (out_ch.tag_high),
  .tag_low   (out_ch.tag_low)
);
